// ----- design/mfmtd_pkg.sv -----
// shared types and constants for the mfm track sync/checksum decoder
// no dependencies; imported by the decoder top, front, queue and back modules

package mfmtd_pkg;

   localparam logic [15:0] SYNC_MARK  = 16'h4489;
   localparam logic [31:0] MFM_MASK   = 32'h5555_5555;
   localparam int          LONG_LIMIT = 2048;

   localparam logic        RST_SYNC_CHECK_ENABLE = 1'b1;
   localparam logic [31:0] RST_SYNC_WORD_FIRST   = 32'h2529_2512;
   localparam logic [31:0] RST_SYNC_WORD_SECOND  = 32'h4552_4911;
   localparam logic [11:0] RST_LONG_COUNT        = 12'h616;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CSR_SYNC_CHECK_ENABLE = 2'd0,
      CSR_SYNC_WORD_FIRST   = 2'd1,
      CSR_SYNC_WORD_SECOND  = 2'd2,
      CSR_LONG_COUNT        = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_SYNC1 = 3'd1,
      PH_SYNC2 = 3'd2,
      PH_SUM   = 3'd3,
      PH_DATA  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      EV_SUM   = 2'd0,
      EV_DATA  = 2'd1,
      EV_ABORT = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic        sync_check_enable;
      logic [31:0] sync_word_first;
      logic [31:0] sync_word_second;
      logic [11:0] long_count;
   } cfg_type;

   typedef struct packed {
      event_kind_type kind;
      logic [31:0]    word;
      logic [10:0]    index;
      logic           last;
   } mfm_event_type;

endpackage

// ----- design/mfm_track_sync_checksum_decoder.sv -----
// Decodes an MFM track from a raw bit stream: hunts for the 0x4489 mark, optionally
// checks two raw 32-bit sync words, then emits even/odd decoded data longs with an
// XOR checksum verdict on the last one. One raw bit is taken per clock cycle while the
// event queue has room; the bit window and phase logic in the front end are updated
// at the clock edge that takes each bit. A decoded long passes through an event queue
// entry and then the result register on its way to the result ports; the input stalls
// only while the event queue is full. No clearing pass after reset.
// Depends on mfmtd_pkg, mfmtd_front, mfmtd_queue and mfmtd_back.

module mfm_track_sync_checksum_decoder import mfmtd_pkg::*; #(
   parameter int MAX_LONGS = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_raw_bit,
   input  logic        req_stream_end,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_data_word,
   output logic [10:0] rsp_word_index,
   output logic        rsp_last,
   output logic        rsp_checksum_good,
   output logic        rsp_aborted,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   logic          item_valid;
   logic          ev_valid;
   mfm_event_type ev;
   logic          q_full;
   logic          q_valid;
   logic          q_pop;
   mfm_event_type q_ev;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SYNC_CHECK_ENABLE: cfg_in.sync_check_enable = csr_wdata[0];
            CSR_SYNC_WORD_FIRST:   cfg_in.sync_word_first   = csr_wdata;
            CSR_SYNC_WORD_SECOND:  cfg_in.sync_word_second  = csr_wdata;
            CSR_LONG_COUNT:        cfg_in.long_count        = csr_wdata[11:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_check_enable <= RST_SYNC_CHECK_ENABLE;
         cfg_ff.sync_word_first   <= RST_SYNC_WORD_FIRST;
         cfg_ff.sync_word_second  <= RST_SYNC_WORD_SECOND;
         cfg_ff.long_count        <= RST_LONG_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full   = q_full;
   assign item_valid = req_push && !q_full;

   mfmtd_front #(
      .MAX_LONGS(MAX_LONGS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .raw_bit    (req_raw_bit),
      .stream_end (req_stream_end),
      .cfg        (cfg_ff),
      .ev_valid   (ev_valid),
      .ev         (ev)
   );

   mfmtd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_valid),
      .push_data (ev),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_ev)
   );

   mfmtd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_ev              (q_ev),
      .q_pop             (q_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_data_word     (rsp_data_word),
      .rsp_word_index    (rsp_word_index),
      .rsp_last          (rsp_last),
      .rsp_checksum_good (rsp_checksum_good),
      .rsp_aborted       (rsp_aborted)
   );

endmodule

// ----- design/mfmtd_front.sv -----
// front end: bit window, sync hunt, phase tracking and even/odd long assembly
// depends on mfmtd_pkg; emits decoded-long and abort events toward the queue

module mfmtd_front import mfmtd_pkg::*; #(
   parameter int MAX_LONGS = 2048
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  logic          raw_bit,
   input  logic          stream_end,
   input  cfg_type       cfg,
   output logic          ev_valid,
   output mfm_event_type ev
);

   localparam int          CAP_INT = (MAX_LONGS < LONG_LIMIT) ? MAX_LONGS : LONG_LIMIT;
   localparam logic [11:0] CAP     = 12'(CAP_INT);

   logic [31:0] window_ff, window_in;
   phase_type   phase_ff, phase_in;
   logic [5:0]  bit_count_ff, bit_count_in;
   logic [31:0] odd_half_ff, odd_half_in;
   logic [10:0] long_counter_ff, long_counter_in;

   logic [31:0] shifted;
   logic [31:0] decoded;
   logic [31:0] expected;
   logic [5:0]  bc_next;
   logic [11:0] count_floor;
   logic [11:0] eff_count;
   logic        at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff       <= '0;
         phase_ff        <= PH_HUNT;
         bit_count_ff    <= '0;
         odd_half_ff     <= '0;
         long_counter_ff <= '0;
      end else begin
         window_ff       <= window_in;
         phase_ff        <= phase_in;
         bit_count_ff    <= bit_count_in;
         odd_half_ff     <= odd_half_in;
         long_counter_ff <= long_counter_in;
      end
   end

   assign shifted     = {window_ff[30:0], raw_bit};
   assign decoded     = ((odd_half_ff & MFM_MASK) << 1) | (shifted & MFM_MASK);
   assign expected    = (phase_ff == PH_SYNC1) ? cfg.sync_word_first : cfg.sync_word_second;
   assign bc_next     = bit_count_ff + 6'd1;
   assign count_floor = (cfg.long_count == 12'd0) ? 12'd1 : cfg.long_count;
   assign eff_count   = (count_floor > CAP) ? CAP : count_floor;
   assign at_end      = ({1'b0, long_counter_ff} + 12'd1) >= eff_count;

   always_comb begin
      window_in       = window_ff;
      phase_in        = phase_ff;
      bit_count_in    = bit_count_ff;
      odd_half_in     = odd_half_ff;
      long_counter_in = long_counter_ff;
      ev_valid        = 1'b0;
      ev.kind         = EV_DATA;
      ev.word         = decoded;
      ev.index        = long_counter_ff;
      ev.last         = 1'b0;
      if (item_valid) begin
         if (stream_end) begin
            if (phase_ff != PH_HUNT) begin
               ev_valid = 1'b1;
               ev.kind  = EV_ABORT;
               ev.last  = 1'b1;
            end
            phase_in     = PH_HUNT;
            window_in    = '0;
            bit_count_in = '0;
         end else begin
            window_in = shifted;
            unique case (phase_ff)
               PH_HUNT: begin
                  if (shifted[15:0] == SYNC_MARK) begin
                     phase_in     = cfg.sync_check_enable ? PH_SYNC1 : PH_SUM;
                     bit_count_in = '0;
                  end
               end
               PH_SYNC1, PH_SYNC2: begin
                  bit_count_in = bc_next;
                  if (bc_next[5]) begin
                     bit_count_in = '0;
                     if (shifted != expected) begin
                        phase_in = PH_HUNT;
                     end else begin
                        phase_in = (phase_ff == PH_SYNC1) ? PH_SYNC2 : PH_SUM;
                     end
                  end
               end
               PH_SUM, PH_DATA: begin
                  bit_count_in = bc_next;
                  if (bc_next == 6'd32) begin
                     odd_half_in = shifted;
                  end else if (bc_next == 6'd0) begin
                     ev_valid = 1'b1;
                     if (phase_ff == PH_SUM) begin
                        ev.kind         = EV_SUM;
                        long_counter_in = '0;
                        phase_in        = PH_DATA;
                     end else begin
                        ev.last = at_end;
                        if (at_end) begin
                           phase_in = PH_HUNT;
                        end else begin
                           long_counter_in = long_counter_ff + 11'd1;
                        end
                     end
                  end
               end
               default: begin
                  phase_in = PH_HUNT;
               end
            endcase
         end
      end
   end

endmodule

// ----- design/mfmtd_queue.sv -----
// short event queue between the front end and the back end
// depends on mfmtd_pkg for the event type and depth

module mfmtd_queue import mfmtd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  mfm_event_type push_data,
   output logic          full,
   input  logic          pop,
   output logic          valid,
   output mfm_event_type pop_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   mfm_event_type              entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   assign full     = (count_ff == ($bits(count_ff))'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/mfmtd_back.sv -----
// back end: checksum accumulation and the registered result slot
// depends on mfmtd_pkg; drains events from mfmtd_queue

module mfmtd_back import mfmtd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  mfm_event_type q_ev,
   output logic          q_pop,
   input  logic          rsp_pop,
   output logic          rsp_empty,
   output logic [31:0]   rsp_data_word,
   output logic [10:0]   rsp_word_index,
   output logic          rsp_last,
   output logic          rsp_checksum_good,
   output logic          rsp_aborted
);

   logic        out_valid_ff, out_valid_in;
   logic [31:0] word_ff, word_in;
   logic [10:0] index_ff, index_in;
   logic        last_ff, last_in;
   logic        good_ff, good_in;
   logic        aborted_ff, aborted_in;
   logic [31:0] stored_sum_ff, stored_sum_in;
   logic [31:0] running_xor_ff, running_xor_in;
   logic [31:0] xor_next;
   logic        slot_free;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign q_pop     = q_valid && slot_free;
   assign xor_next  = running_xor_ff ^ q_ev.word;

   always_comb begin
      out_valid_in   = out_valid_ff && !rsp_pop;
      word_in        = word_ff;
      index_in       = index_ff;
      last_in        = last_ff;
      good_in        = good_ff;
      aborted_in     = aborted_ff;
      stored_sum_in  = stored_sum_ff;
      running_xor_in = running_xor_ff;
      if (q_pop) begin
         unique case (q_ev.kind)
            EV_SUM: begin
               stored_sum_in  = q_ev.word;
               running_xor_in = '0;
            end
            EV_DATA: begin
               running_xor_in = xor_next;
               out_valid_in   = 1'b1;
               word_in        = q_ev.word;
               index_in       = q_ev.index;
               last_in        = q_ev.last;
               good_in        = q_ev.last && (xor_next == stored_sum_ff);
               aborted_in     = 1'b0;
            end
            EV_ABORT: begin
               out_valid_in = 1'b1;
               word_in      = '0;
               index_in     = q_ev.index;
               last_in      = 1'b1;
               good_in      = 1'b0;
               aborted_in   = 1'b1;
            end
            default: begin
               out_valid_in = out_valid_ff && !rsp_pop;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         stored_sum_ff  <= '0;
         running_xor_ff <= '0;
      end else begin
         out_valid_ff   <= out_valid_in;
         stored_sum_ff  <= stored_sum_in;
         running_xor_ff <= running_xor_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      index_ff   <= index_in;
      last_ff    <= last_in;
      good_ff    <= good_in;
      aborted_ff <= aborted_in;
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_data_word     = word_ff;
   assign rsp_word_index    = index_ff;
   assign rsp_last          = last_ff;
   assign rsp_checksum_good = good_ff;
   assign rsp_aborted       = aborted_ff;

endmodule

// ----- design/mfmtd_checker.sv -----
// port-level checks for mfm_track_sync_checksum_decoder
// bound to the top level; depends only on its ports

module mfmtd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_data_word,
   input logic [10:0] rsp_word_index,
   input logic        rsp_last,
   input logic        rsp_checksum_good,
   input logic        rsp_aborted
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("result queue not empty or input full after reset");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data_word)
         && $stable(rsp_word_index) && $stable(rsp_last) && $stable(rsp_aborted)))
      else $error("waiting result changed before transfer");

   a_abort_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_aborted) |-> (rsp_last && !rsp_checksum_good
         && rsp_data_word == 32'd0))
      else $error("abort result malformed");

   a_good_on_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_checksum_good) |-> (rsp_last && !rsp_aborted))
      else $error("checksum verdict outside final long");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last) ##1 (!rsp_empty && !rsp_aborted)
         |-> (rsp_word_index == $past(rsp_word_index) + 11'd1))
      else $error("data long index did not advance");

endmodule

bind mfm_track_sync_checksum_decoder mfmtd_checker u_mfmtd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_full          (req_full),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_data_word     (rsp_data_word),
   .rsp_word_index    (rsp_word_index),
   .rsp_last          (rsp_last),
   .rsp_checksum_good (rsp_checksum_good),
   .rsp_aborted       (rsp_aborted)
);

// ----- sim/mfm_track_decode_checker.sv -----
`timescale 1ns / 1ps
// transfer checker for the mfm track sync/checksum decoder: follows the bit, result
// and register channels, decodes each accepted raw bit and compares every decoded long
// depends on mfmtd_pkg; instantiated beside the decoder by tb_mfm_track_sync_checksum_decoder

module mfm_track_decode_checker import mfmtd_pkg::*; #(
   parameter int MAX_LONGS = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic        req_raw_bit,
   input  logic        req_stream_end,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [31:0] rsp_data_word,
   input  logic [10:0] rsp_word_index,
   input  logic        rsp_last,
   input  logic        rsp_checksum_good,
   input  logic        rsp_aborted,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fault_count,
   output int          longs_in_flight
);

   typedef struct packed {
      logic [31:0] data_word;
      logic [10:0] word_index;
      logic        last;
      logic        checksum_good;
      logic        aborted;
   } track_long_type;

   cfg_type        regs;
   logic [31:0]    window;
   phase_type      phase;
   logic [5:0]     bit_count;
   logic [31:0]    odd_half;
   logic [31:0]    stored_sum;
   logic [31:0]    running_xor;
   logic [10:0]    long_index;
   track_long_type decoded_longs[$];

   function automatic int track_length();
      int n;
      n = int'(regs.long_count);
      if (n == 0) n = 1;
      if (n > MAX_LONGS) n = MAX_LONGS;
      if (n > LONG_LIMIT) n = LONG_LIMIT;
      return n;
   endfunction

   task automatic decode_bit(input logic raw, input logic stream_end);
      logic [31:0] word;
      if (stream_end) begin
         if (phase != PH_HUNT)
            decoded_longs.push_back('{32'h0, long_index, 1'b1, 1'b0, 1'b1});
         phase = PH_HUNT;
         window = '0;
         bit_count = '0;
         return;
      end
      window = {window[30:0], raw};
      if (phase == PH_HUNT) begin
         if (window[15:0] == SYNC_MARK) begin
            phase = regs.sync_check_enable ? PH_SYNC1 : PH_SUM;
            bit_count = '0;
         end
         return;
      end
      bit_count = bit_count + 1'b1;
      if (phase == PH_SYNC1 || phase == PH_SYNC2) begin
         if (bit_count < 6'd32) return;
         bit_count = '0;
         word = (phase == PH_SYNC1) ? regs.sync_word_first : regs.sync_word_second;
         if (window != word)
            phase = PH_HUNT;
         else
            phase = (phase == PH_SYNC1) ? PH_SYNC2 : PH_SUM;
         return;
      end
      if (bit_count == 6'd32) begin
         odd_half = window;
         return;
      end
      // a full even/odd pair wraps the 6-bit count back to zero
      if (bit_count != 6'd0) return;
      word = ((odd_half & MFM_MASK) << 1) | (window & MFM_MASK);
      if (phase == PH_SUM) begin
         stored_sum = word;
         running_xor = '0;
         long_index = '0;
         phase = PH_DATA;
         return;
      end
      running_xor = running_xor ^ word;
      if (int'(long_index) + 1 >= track_length()) begin
         decoded_longs.push_back('{word, long_index, 1'b1, running_xor == stored_sum, 1'b0});
         phase = PH_HUNT;
      end else begin
         decoded_longs.push_back('{word, long_index, 1'b0, 1'b0, 1'b0});
         long_index = long_index + 1'b1;
      end
   endtask

   always @(posedge clock) begin : watch
      track_long_type want;
      if (reset) begin
         regs.sync_check_enable = RST_SYNC_CHECK_ENABLE;
         regs.sync_word_first = RST_SYNC_WORD_FIRST;
         regs.sync_word_second = RST_SYNC_WORD_SECOND;
         regs.long_count = RST_LONG_COUNT;
         window = '0;
         phase = PH_HUNT;
         bit_count = '0;
         odd_half = '0;
         stored_sum = '0;
         running_xor = '0;
         long_index = '0;
         decoded_longs.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (decoded_longs.size() == 0) begin
               $error("unexpected result: word_index %0d data_word %h",
                      rsp_word_index, rsp_data_word);
               fault_count++;
            end else begin
               want = decoded_longs.pop_front();
               if (rsp_data_word !== want.data_word) begin
                  $error("data_word expected %h actual %h", want.data_word, rsp_data_word);
                  fault_count++;
               end
               if (rsp_word_index !== want.word_index) begin
                  $error("word_index expected %0d actual %0d", want.word_index,
                         rsp_word_index);
                  fault_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last expected %b actual %b", want.last, rsp_last);
                  fault_count++;
               end
               if (rsp_checksum_good !== want.checksum_good) begin
                  $error("checksum_good expected %b actual %b", want.checksum_good,
                         rsp_checksum_good);
                  fault_count++;
               end
               if (rsp_aborted !== want.aborted) begin
                  $error("aborted expected %b actual %b", want.aborted, rsp_aborted);
                  fault_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SYNC_CHECK_ENABLE: regs.sync_check_enable = csr_wdata[0];
               CSR_SYNC_WORD_FIRST:   regs.sync_word_first = csr_wdata;
               CSR_SYNC_WORD_SECOND:  regs.sync_word_second = csr_wdata;
               CSR_LONG_COUNT:        regs.long_count = csr_wdata[11:0];
               default: ;
            endcase
         end
         if (req_push && !req_full)
            decode_bit(req_raw_bit, req_stream_end);
      end
      longs_in_flight = decoded_longs.size();
   end

endmodule

// ----- sim/tb_mfm_track_sync_checksum_decoder.sv -----
`timescale 1ns / 1ps
// top-level testbench for mfm_track_sync_checksum_decoder: clock, reset, raw bit
// frames and noise, result-side back-pressure, register writes and the verdict
// depends on mfmtd_pkg, the decoder rtl and mfm_track_decode_checker

module tb_mfm_track_sync_checksum_decoder;
   import mfmtd_pkg::*;

   localparam int TRACK_LIMIT  = 2048;
   localparam int QUIET_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 900;
   localparam int DRAIN_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic        req_raw_bit;
   logic        req_stream_end;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [31:0] rsp_data_word;
   logic [10:0] rsp_word_index;
   logic        rsp_last;
   logic        rsp_checksum_good;
   logic        rsp_aborted;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   int fault_count;
   int longs_in_flight;
   int bits_sent = 0;
   int abort_left;
   bit frame_cut;
   bit req_idle_on;
   bit rsp_idle_on;
   bit hold_rsp;

   logic        cur_sync_en;
   logic [31:0] cur_first;
   logic [31:0] cur_second;
   logic [11:0] cur_count;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   mfm_track_sync_checksum_decoder #(.MAX_LONGS(TRACK_LIMIT)) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_raw_bit       (req_raw_bit),
      .req_stream_end    (req_stream_end),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_data_word     (rsp_data_word),
      .rsp_word_index    (rsp_word_index),
      .rsp_last          (rsp_last),
      .rsp_checksum_good (rsp_checksum_good),
      .rsp_aborted       (rsp_aborted),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   mfm_track_decode_checker #(.MAX_LONGS(TRACK_LIMIT)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_raw_bit       (req_raw_bit),
      .req_stream_end    (req_stream_end),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_data_word     (rsp_data_word),
      .rsp_word_index    (rsp_word_index),
      .rsp_last          (rsp_last),
      .rsp_checksum_good (rsp_checksum_good),
      .rsp_aborted       (rsp_aborted),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fault_count       (fault_count),
      .longs_in_flight   (longs_in_flight)
   );

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_pop = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 11) == 0) begin
            rsp_pop = 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clock);
         end else begin
            rsp_pop = 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   function automatic int track_len();
      int n;
      n = int'(cur_count);
      if (n == 0) n = 1;
      if (n > TRACK_LIMIT) n = TRACK_LIMIT;
      return n;
   endfunction

   function automatic logic [31:0] pick_word(input logic [31:0] usual);
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2, 3: return $urandom;
         default: return usual;
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic drive_bit(input logic raw, input logic stream_end);
      if (req_idle_on && $urandom_range(0, 11) == 0) begin
         req_push = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_push = 1'b1;
      req_raw_bit = raw;
      req_stream_end = stream_end;
      @(posedge clock);
      while (req_full) @(posedge clock);
      bits_sent++;
      @(negedge clock);
   endtask

   task automatic quiesce();
      req_push = 1'b0;
      while (longs_in_flight != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      quiesce();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
      case (idx)
         CSR_SYNC_CHECK_ENABLE: cur_sync_en = value[0];
         CSR_SYNC_WORD_FIRST:   cur_first = value;
         CSR_SYNC_WORD_SECOND:  cur_second = value;
         CSR_LONG_COUNT:        cur_count = value[11:0];
         default: ;
      endcase
   endtask

   task automatic send_noise(input int n);
      repeat (n) drive_bit($urandom_range(0, 1), $urandom_range(0, 15) == 0);
   endtask

   // frame bit, replaced by an end of stream at the chosen abort point
   task automatic frame_bit(input logic b);
      if (!frame_cut) begin
         if (abort_left == 0) begin
            drive_bit($urandom_range(0, 1), 1'b1);
            frame_cut = 1'b1;
         end else begin
            drive_bit(b, 1'b0);
            abort_left--;
         end
      end
   endtask

   task automatic send_word(input logic [31:0] w, input int n);
      for (int i = n - 1; i >= 0; i--) frame_bit(w[i]);
   endtask

   task automatic send_long(input logic [31:0] value);
      logic [31:0] filler;
      filler = $urandom;
      send_word(((value >> 1) & MFM_MASK) | (filler & ~MFM_MASK), 32);
      filler = $urandom;
      send_word((value & MFM_MASK) | (filler & ~MFM_MASK), 32);
   endtask

   task automatic send_body(input int n_longs, input bit sum_ok);
      logic [31:0] longs[$];
      logic [31:0] parity;
      logic [31:0] v;
      parity = '0;
      for (int i = 0; i < n_longs; i++) begin
         case ($urandom_range(0, 7))
            0: v = 32'h0;
            1: v = 32'hFFFF_FFFF;
            default: v = $urandom;
         endcase
         longs.push_back(v);
         parity = parity ^ v;
      end
      if (!sum_ok) parity = parity ^ (32'h1 << $urandom_range(0, 31));
      send_long(parity);
      foreach (longs[i]) send_long(longs[i]);
   endtask

   task automatic send_frame(input int n_longs, input bit sum_ok, input int abort_at,
                             input int bad_sync);
      logic [31:0] flip;
      flip = 32'h1 << $urandom_range(0, 31);
      send_noise($urandom_range(0, 12));
      frame_cut = 1'b0;
      abort_left = abort_at;
      send_word({16'h0, SYNC_MARK}, 16);
      if (cur_sync_en) begin
         send_word(bad_sync == 1 ? cur_first ^ flip : cur_first, 32);
         send_word(bad_sync == 2 ? cur_second ^ flip : cur_second, 32);
      end
      send_body(n_longs, sum_ok);
   endtask

   initial begin
      int frame_bits;
      reset = 1'b1;
      req_push = 1'b0;
      req_raw_bit = 1'b0;
      req_stream_end = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_SYNC_CHECK_ENABLE;
      csr_wdata = '0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      hold_rsp = 1'b0;
      frame_cut = 1'b0;
      abort_left = -1;
      cur_sync_en = RST_SYNC_CHECK_ENABLE;
      cur_first = RST_SYNC_WORD_FIRST;
      cur_second = RST_SYNC_WORD_SECOND;
      cur_count = RST_LONG_COUNT;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed frames with the reset sync words
      write_reg(CSR_LONG_COUNT, 32'd2);
      drive_bit(1'b1, 1'b1);
      send_noise(6);
      drive_bit(1'b0, 1'b1);
      send_frame(2, 1'b1, -1, 0);
      send_frame(2, 1'b0, -1, 0);
      send_frame(2, 1'b1, -1, 1);
      send_frame(2, 1'b1, -1, 2);
      send_frame(2, 1'b1, 16 + 5, 0);
      send_frame(2, 1'b1, 16 + 40, 0);
      send_frame(2, 1'b1, 16 + 64 + 20, 0);
      send_frame(2, 1'b1, 16 + 128 + 64 + 3, 0);

      // sync mismatch whose next bit completes a new mark
      frame_cut = 1'b0;
      abort_left = -1;
      send_word({16'h0, SYNC_MARK}, 16);
      send_word(32'h0002_2244, 32);
      send_word(32'h1, 1);
      send_word(cur_first, 32);
      send_word(cur_second, 32);
      send_body(2, 1'b1);
      // mismatch word already ending in the mark
      send_word({16'h0, SYNC_MARK}, 16);
      send_word(32'h1234_4489, 32);
      send_noise(20);

      write_reg(CSR_LONG_COUNT, 32'd0);
      send_frame(1, 1'b1, -1, 0);
      write_reg(CSR_SYNC_CHECK_ENABLE, 32'd0);
      send_frame(1, 1'b1, -1, 0);
      send_frame(1, 1'b0, 16 + 30, 0);
      write_reg(CSR_SYNC_CHECK_ENABLE, 32'd1);
      write_reg(CSR_SYNC_WORD_FIRST, 32'h0);
      write_reg(CSR_SYNC_WORD_SECOND, 32'hFFFF_FFFF);
      write_reg(CSR_LONG_COUNT, 32'd1);
      send_frame(1, 1'b1, -1, 0);
      send_frame(1, 1'b0, -1, 0);

      // track length shortened while a frame is in its data longs
      write_reg(CSR_LONG_COUNT, 32'd8);
      frame_cut = 1'b0;
      abort_left = -1;
      send_word({16'h0, SYNC_MARK}, 16);
      send_word(cur_first, 32);
      send_word(cur_second, 32);
      send_long($urandom);
      repeat (3) send_long($urandom);
      write_reg(CSR_LONG_COUNT, 32'd2);
      repeat (2) send_long($urandom);

      // saturated track length, cut after a dozen longs while the receiver holds off
      write_reg(CSR_SYNC_CHECK_ENABLE, 32'd0);
      write_reg(CSR_LONG_COUNT, 32'hFFF);
      hold_rsp = 1'b1;
      send_frame(track_len(), 1'b1, 16 + 64 * 12, 0);

      write_reg(CSR_SYNC_CHECK_ENABLE, 32'd1);
      write_reg(CSR_SYNC_WORD_FIRST, RST_SYNC_WORD_FIRST);
      write_reg(CSR_SYNC_WORD_SECOND, RST_SYNC_WORD_SECOND);
      write_reg(CSR_LONG_COUNT, 32'd3);

      bits_sent = 0;
      for (int f = 0; bits_sent < 550; f++) begin
         if (f % 4 == 3) begin
            write_reg(CSR_SYNC_CHECK_ENABLE, $urandom_range(0, 1));
            write_reg(CSR_SYNC_WORD_FIRST, pick_word(RST_SYNC_WORD_FIRST));
            write_reg(CSR_SYNC_WORD_SECOND, pick_word(RST_SYNC_WORD_SECOND));
            if ($urandom_range(0, 7) == 0)
               write_reg(CSR_LONG_COUNT, $urandom_range(7, 40));
            else
               write_reg(CSR_LONG_COUNT, $urandom_range(0, 6));
         end
         req_idle_on = $urandom_range(0, 3) != 0;
         rsp_idle_on = $urandom_range(0, 3) != 0;
         frame_bits = 16 + (cur_sync_en ? 64 : 0) + 64 * (track_len() + 1);
         case ($urandom_range(0, 19))
            14, 15: send_frame(track_len(), 1'b1, -1, $urandom_range(1, 2));
            16, 17: send_frame(track_len(), $urandom_range(0, 1),
                               $urandom_range(0, frame_bits - 1), 0);
            18: send_noise($urandom_range(20, 80));
            19: send_frame(track_len() + 1, $urandom_range(0, 1), -1, 0);
            default: send_frame(track_len(), $urandom_range(0, 1), -1, 0);
         endcase
      end

      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (3) send_frame(track_len(), 1'b1, -1, 0);
      req_push = 1'b0;
      while (longs_in_flight != 0) @(negedge clock);
      repeat (4 * DRAIN_CYCLES) @(negedge clock);
      if (fault_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
